// ===== rtl/core/rtu35_pkg.sv =====
// Types, constants and channel blend functions for the 3x3 to 5x5 tile upscaler.
`default_nettype none

package rtu35_pkg;

    typedef logic [15:0] t_pixel;
    typedef logic [2:0]  t_row_num;

    // Three pixels of one tile row, index 0 at the left
    typedef t_pixel [2:0] t_trio;
    // Five pixels of one output row, index 0 at the left
    typedef t_pixel [4:0] t_five;

    typedef struct packed {
        t_trio bottom;
        t_trio mid;
        t_trio top;
    } t_tile;

    localparam t_row_num ROW_TOP_SRC   = 3'd0;
    localparam t_row_num ROW_TOP_BLEND = 3'd1;
    localparam t_row_num ROW_MID_SRC   = 3'd2;
    localparam t_row_num ROW_BOT_BLEND = 3'd3;
    localparam t_row_num ROW_BOT_SRC   = 3'd4;
    localparam t_row_num ROW_LAST      = ROW_BOT_SRC;

    // floor(x / 3) for x below 192: multiply by 171, keep product bits 14 down to 9
    localparam logic [7:0] RECIP3 = 8'd171;

    function automatic logic [5:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        prod = {8'd0, x} * {8'd0, RECIP3};
        return prod[14:9];
    endfunction

    // (2p + q) / 3 on each colour field, truncated
    function automatic t_pixel blend_hi(input t_pixel p, input t_pixel q);
        logic [7:0] sum_r;
        logic [7:0] sum_g;
        logic [7:0] sum_b;
        logic [5:0] quo_r;
        logic [5:0] quo_g;
        logic [5:0] quo_b;
        sum_r = {2'd0, p[15:11], 1'b0} + {3'd0, q[15:11]};
        sum_g = {1'b0, p[10:5], 1'b0}  + {2'd0, q[10:5]};
        sum_b = {2'd0, p[4:0], 1'b0}   + {3'd0, q[4:0]};
        quo_r = div3(sum_r);
        quo_g = div3(sum_g);
        quo_b = div3(sum_b);
        return {quo_r[4:0], quo_g, quo_b[4:0]};
    endfunction

    // Widen a tile row to five pixels: sources on even places, blends between
    function automatic t_five expand(input t_trio t);
        t_five w;
        w[0] = t[0];
        w[1] = blend_hi(t[0], t[1]);
        w[2] = t[1];
        w[3] = blend_hi(t[2], t[1]);
        w[4] = t[2];
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtu35_if.sv =====
// Handshake interfaces for the tile input channel and the row result channel.
`default_nettype none

interface rtu35_tile_if;
    logic        valid;
    logic        ready;
    logic [15:0] in_top_left;
    logic [15:0] in_top_center;
    logic [15:0] in_top_right;
    logic [15:0] in_mid_left;
    logic [15:0] in_mid_center;
    logic [15:0] in_mid_right;
    logic [15:0] in_bottom_left;
    logic [15:0] in_bottom_center;
    logic [15:0] in_bottom_right;

    modport source (
        output valid, in_top_left, in_top_center, in_top_right,
               in_mid_left, in_mid_center, in_mid_right,
               in_bottom_left, in_bottom_center, in_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, in_top_left, in_top_center, in_top_right,
               in_mid_left, in_mid_center, in_mid_right,
               in_bottom_left, in_bottom_center, in_bottom_right,
        output ready
    );
endinterface

interface rtu35_row_if;
    logic        valid;
    logic        ready;
    logic [2:0]  row_number;
    logic [15:0] out_col0;
    logic [15:0] out_col1;
    logic [15:0] out_col2;
    logic [15:0] out_col3;
    logic [15:0] out_col4;
    logic        last_row;

    modport source (
        output valid, row_number, out_col0, out_col1, out_col2, out_col3,
               out_col4, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_number, out_col0, out_col1, out_col2, out_col3,
               out_col4, last_row,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/rtu35_row_gen.sv =====
// Builds one output row of the 5x5 tile from a held 3x3 tile.
`default_nettype none

module rtu35_row_gen
    import rtu35_pkg::*;
(
    input  t_tile    i_tile,
    input  t_row_num i_row,
    output t_five    o_pix
);

    t_trio sel_row;
    t_five sel_wide;
    t_five mid_wide;
    logic  odd_row;

    // Odd rows lean towards the outer row; the middle row is always the partner
    always_comb begin
        case (i_row) inside
            ROW_TOP_SRC, ROW_TOP_BLEND: sel_row = i_tile.top;
            ROW_MID_SRC:                sel_row = i_tile.mid;
            ROW_BOT_BLEND, ROW_BOT_SRC: sel_row = i_tile.bottom;
            default:                    sel_row = i_tile.mid;
        endcase
    end

    assign odd_row  = (i_row == ROW_TOP_BLEND) || (i_row == ROW_BOT_BLEND);
    assign sel_wide = expand(sel_row);
    assign mid_wide = expand(i_tile.mid);

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            o_pix[k] = odd_row ? blend_hi(sel_wide[k], mid_wide[k]) : sel_wide[k];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgb565_tile_upscale_3to5.sv =====
// Top level: 3x3 RGB565 tile in, five rows of a 5x5 upscaled tile out.
//
//  channel  | dir | word                       | handshake
//  ---------+-----+----------------------------+-------------
//  i_tile   | in  | nine RGB565 pixels (3x3)   | valid/ready
//  o_row    | out | row number, 5 pixels, last | valid/ready
//
// Five rows per tile; the row result channel carries one row per cycle unless o_row stalls.
// The first row of a tile reaches o_row through the tile register and the output register.
// Reset clears the tile and result valid flags and the row counter.
// A stalled result holds in the output register; the tile register holds
// and i_tile.ready stays low until the tile's last row moves into the output
// register.
`default_nettype none

module rgb565_tile_upscale_3to5
    import rtu35_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    rtu35_tile_if.sink  i_tile,
    rtu35_row_if.source o_row
);

    t_tile    r_tile;
    logic     r_tile_vld;
    logic     n_tile_vld;
    t_row_num r_row;
    t_row_num n_row;
    t_five    r_out_pix;
    t_row_num r_out_row;
    logic     r_out_last;
    logic     r_out_vld;
    logic     n_out_vld;

    t_tile    in_tile;
    t_five    row_pix;
    logic     advance;
    logic     tile_done;
    logic     take;

    always_comb begin
        in_tile.top    = {i_tile.in_top_right, i_tile.in_top_center, i_tile.in_top_left};
        in_tile.mid    = {i_tile.in_mid_right, i_tile.in_mid_center, i_tile.in_mid_left};
        in_tile.bottom = {i_tile.in_bottom_right, i_tile.in_bottom_center,
                          i_tile.in_bottom_left};
    end

    rtu35_row_gen u_row_gen (
        .i_tile (r_tile),
        .i_row  (r_row),
        .o_pix  (row_pix)
    );

    // Advance one row when the output register is free or being emptied
    assign advance   = r_tile_vld && (!r_out_vld || o_row.ready);
    assign tile_done = advance && (r_row == ROW_LAST);
    assign take      = i_tile.valid && i_tile.ready;

    assign i_tile.ready = !r_tile_vld || tile_done;

    always_comb begin
        n_tile_vld = r_tile_vld;
        n_row      = r_row;
        n_out_vld  = r_out_vld;
        if (o_row.ready) begin
            n_out_vld = 1'b0;
        end
        if (advance) begin
            n_out_vld = 1'b1;
            n_row     = tile_done ? ROW_TOP_SRC : r_row + 3'd1;
        end
        if (tile_done) begin
            n_tile_vld = 1'b0;
        end
        if (take) begin
            n_tile_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_vld <= 1'b0;
            r_row      <= ROW_TOP_SRC;
            r_out_vld  <= 1'b0;
        end else begin
            r_tile_vld <= n_tile_vld;
            r_row      <= n_row;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tile <= in_tile;
        end
        if (advance) begin
            r_out_pix  <= row_pix;
            r_out_row  <= r_row;
            r_out_last <= (r_row == ROW_LAST);
        end
    end

    assign o_row.valid      = r_out_vld;
    assign o_row.row_number = r_out_row;
    assign o_row.out_col0   = r_out_pix[0];
    assign o_row.out_col1   = r_out_pix[1];
    assign o_row.out_col2   = r_out_pix[2];
    assign o_row.out_col3   = r_out_pix[3];
    assign o_row.out_col4   = r_out_pix[4];
    assign o_row.last_row   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/rtu35_checker.sv =====
// Port-level checks for the tile upscaler, bound to the top level.
`default_nettype none

module rtu35_checker
    import rtu35_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  i_row_number,
    input wire [15:0] i_out_col0,
    input wire        i_last_row
);

    t_row_num r_exp_row;

    // Track which row should come next on the result channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= ROW_TOP_SRC;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_row <= (i_row_number == ROW_LAST) ? ROW_TOP_SRC : i_row_number + 3'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_row_number == r_exp_row))
        else $error("row out of order");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_row == (i_row_number == ROW_LAST)))
        else $error("last row mark wrong");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_row_number) && $stable(i_out_col0)))
        else $error("stalled word changed");

endmodule

bind rgb565_tile_upscale_3to5 rtu35_checker u_rtu35_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_row.valid),
    .i_out_ready  (o_row.ready),
    .i_row_number (o_row.row_number),
    .i_out_col0   (o_row.out_col0),
    .i_last_row   (o_row.last_row)
);

`default_nettype wire

// ===== sim/tb_rgb565_tile_upscale_3to5.sv =====
// Testbench for the 3x3 to 5x5 RGB565 tile upscaler: directed and random tiles, row scoreboard.
`timescale 1ns / 100ps

module tb_rgb565_tile_upscale_3to5;
    import rtu35_pkg::*;

    typedef struct packed {
        t_row_num row;
        t_five    px;
        logic     last;
    } t_row_word;

    class row_scoreboard;
        t_row_word rows_q[$];
        int        errors;
        int        rows_seen;

        function new();
            errors    = 0;
            rows_seen = 0;
        endfunction

        // Per-channel (2p + q) / 3, truncated
        function t_pixel mix(t_pixel p, t_pixel q);
            int r;
            int g;
            int b;
            r = (2 * int'(p[15:11]) + int'(q[15:11])) / 3;
            g = (2 * int'(p[10:5]) + int'(q[10:5])) / 3;
            b = (2 * int'(p[4:0]) + int'(q[4:0])) / 3;
            return {r[4:0], g[5:0], b[4:0]};
        endfunction

        // Sources on even columns, nearer-weighted blends on odd ones
        function t_five widen(t_trio s);
            t_five w;
            w[0] = s[0];
            w[1] = mix(s[0], s[1]);
            w[2] = s[1];
            w[3] = mix(s[2], s[1]);
            w[4] = s[2];
            return w;
        endfunction

        function void note_tile(t_tile t);
            t_five     top_w;
            t_five     mid_w;
            t_five     bot_w;
            t_row_word w;
            top_w = widen(t.top);
            mid_w = widen(t.mid);
            bot_w = widen(t.bottom);
            for (int r = 0; r < 5; r++) begin
                w.row  = t_row_num'(r);
                w.last = (w.row == ROW_LAST);
                for (int k = 0; k < 5; k++) begin
                    case (w.row)
                        ROW_TOP_SRC:   w.px[k] = top_w[k];
                        ROW_TOP_BLEND: w.px[k] = mix(top_w[k], mid_w[k]);
                        ROW_MID_SRC:   w.px[k] = mid_w[k];
                        ROW_BOT_BLEND: w.px[k] = mix(bot_w[k], mid_w[k]);
                        default:       w.px[k] = bot_w[k];
                    endcase
                end
                rows_q.push_back(w);
            end
        endfunction

        function int pending();
            return rows_q.size();
        endfunction

        task report(string what, int got_v, int exp_v);
            $display("row word %0d: %s got 0x%0h expected 0x%0h", rows_seen, what, got_v, exp_v);
            errors++;
        endtask

        task check_row(t_row_word got);
            t_row_word want;
            if (rows_q.size() == 0) begin
                report("unexpected word", got.row, 0);
            end else begin
                want = rows_q.pop_front();
                if (got.row !== want.row)
                    report("row_number", got.row, want.row);
                for (int k = 0; k < 5; k++) begin
                    if (got.px[k] !== want.px[k])
                        report($sformatf("out_col%0d", k), got.px[k], want.px[k]);
                end
                if (got.last !== want.last)
                    report("last_row", got.last, want.last);
            end
            rows_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    rtu35_tile_if tile_if();
    rtu35_row_if  row_if();

    rgb565_tile_upscale_3to5 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tile  (tile_if.sink),
        .o_row   (row_if.source)
    );

    row_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    int rx_hold;
    int stall_left;

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Mostly short, now and then long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: p = t_pixel'($urandom);
            5:       p = 16'h0000;
            6:       p = 16'hffff;
            7:       p = {($urandom_range(0, 1) ? 5'h1f : 5'h00),
                          ($urandom_range(0, 1) ? 6'h3f : 6'h00),
                          ($urandom_range(0, 1) ? 5'h1f : 5'h00)};
            8:       p = {5'(31 - $urandom_range(0, 2)), 6'(63 - $urandom_range(0, 2)),
                          5'(31 - $urandom_range(0, 2))};
            default: p = t_pixel'($urandom) & 16'h0821;
        endcase
        return p;
    endfunction

    function automatic t_tile rand_tile();
        t_tile  t;
        t_pixel p;
        if ($urandom_range(0, 9) < 8) begin
            for (int k = 0; k < 3; k++) begin
                t.top[k]    = rand_pixel();
                t.mid[k]    = rand_pixel();
                t.bottom[k] = rand_pixel();
            end
        end else begin
            // flat tile
            p = rand_pixel();
            for (int k = 0; k < 3; k++) begin
                t.top[k]    = p;
                t.mid[k]    = p;
                t.bottom[k] = p;
            end
        end
        return t;
    endfunction

    function automatic t_tile flat_tile(t_pixel p, t_pixel q);
        t_tile t;
        for (int k = 0; k < 3; k++) begin
            t.top[k]    = (k % 2 == 0) ? p : q;
            t.mid[k]    = (k % 2 == 1) ? p : q;
            t.bottom[k] = (k % 2 == 0) ? p : q;
        end
        return t;
    endfunction

    // Offer one tile from a falling edge; return at the falling edge after it is taken
    task automatic push_tile(t_tile t);
        tile_if.valid            <= 1'b1;
        tile_if.in_top_left      <= t.top[0];
        tile_if.in_top_center    <= t.top[1];
        tile_if.in_top_right     <= t.top[2];
        tile_if.in_mid_left      <= t.mid[0];
        tile_if.in_mid_center    <= t.mid[1];
        tile_if.in_mid_right     <= t.mid[2];
        tile_if.in_bottom_left   <= t.bottom[0];
        tile_if.in_bottom_center <= t.bottom[1];
        tile_if.in_bottom_right  <= t.bottom[2];
        @(posedge clk);
        while (!tile_if.ready)
            @(posedge clk);
        sb.note_tile(t);
        @(negedge clk);
    endtask

    task automatic send_tile(t_tile t);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 99) < 35)
            gap = pick_len();
        if (gap > 0) begin
            tile_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push_tile(t);
    endtask

    task automatic drain();
        tile_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Result side: sample on the rising edge, decide ready on the falling edge
    initial begin
        t_row_word got;
        row_if.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && row_if.valid && row_if.ready) begin
                got.row   = row_if.row_number;
                got.px[0] = row_if.out_col0;
                got.px[1] = row_if.out_col1;
                got.px[2] = row_if.out_col2;
                got.px[3] = row_if.out_col3;
                got.px[4] = row_if.out_col4;
                got.last  = row_if.last_row;
                sb.check_row(got);
            end
            @(negedge clk);
            if (!rst_n) begin
                row_if.ready <= 1'b0;
            end else if (rx_hold > 0) begin
                row_if.ready <= 1'b0;
                rx_hold--;
            end else if (!rx_idle) begin
                row_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                row_if.ready <= 1'b0;
                stall_left--;
            end else begin
                row_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_len();
            end
        end
    end

    initial begin
        t_tile t;
        tile_if.valid            <= 1'b0;
        tile_if.in_top_left      <= '0;
        tile_if.in_top_center    <= '0;
        tile_if.in_top_right     <= '0;
        tile_if.in_mid_left      <= '0;
        tile_if.in_mid_center    <= '0;
        tile_if.in_mid_right     <= '0;
        tile_if.in_bottom_left   <= '0;
        tile_if.in_bottom_center <= '0;
        tile_if.in_bottom_right  <= '0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 0;
        rst_n   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, channel maxima, alternating patterns, lone pixels, a ramp
        push_tile(flat_tile(16'h0000, 16'h0000));
        push_tile(flat_tile(16'hffff, 16'hffff));
        push_tile(flat_tile(16'hf800, 16'hf800));
        push_tile(flat_tile(16'h07e0, 16'h07e0));
        push_tile(flat_tile(16'h001f, 16'h001f));
        push_tile(flat_tile(16'hffff, 16'h0000));
        push_tile(flat_tile(16'h0000, 16'hffff));
        push_tile(flat_tile(16'haaaa, 16'h5555));
        push_tile(flat_tile(16'hf81f, 16'h07e0));
        for (int n = 0; n < 9; n++) begin
            t = flat_tile(16'h0000, 16'h0000);
            t[n*16 +: 16] = 16'hffff;
            push_tile(t);
        end
        t = flat_tile(16'hffff, 16'hffff);
        t.mid[1] = 16'h0000;
        push_tile(t);
        for (int k = 0; k < 3; k++) begin
            t.top[k]    = t_pixel'(16'h0841 * (k + 1));
            t.mid[k]    = t_pixel'(16'h0841 * (k + 4));
            t.bottom[k] = t_pixel'(16'h0841 * (k + 7));
        end
        push_tile(t);

        // Random part, with idling changed every 30 tiles
        for (int n = 0; n < 290; n++) begin
            if (n % 30 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (n == 100) begin
                // hold the result side off and keep offering tiles until the input stalls
                rx_hold = 80;
                tx_idle = 1'b0;
            end
            if (n == 200)
                drain();
            send_tile(rand_tile());
        end

        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("rgb565_tile_upscale_3to5 regression: pass");
        else
            $display("rgb565_tile_upscale_3to5 regression: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("rgb565_tile_upscale_3to5 regression: fail");
        $finish;
    end

endmodule
